// ----- rtl/deadline_slack_task_scheduler_top_assert.svh -----
// assertion macros for the task scheduler
`ifndef DEADLINE_SLACK_TASK_SCHEDULER_TOP_ASSERT_SVH
`define DEADLINE_SLACK_TASK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define DSTS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication
`define DSTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ----- rtl/dsts_pkg.sv -----
`default_nettype none

package dsts_pkg;

    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int KEY_W     = 18;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_TICK   = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_IDLE      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] remaining;
    } entry_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] deadline_time;
        logic [TIME_W-1:0] exec_time;
        logic [TIME_W-1:0] current_time;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] selected_id;
        logic            task_done;
        status_t         status;
    } result_t;

    typedef struct packed {
        logic clear;
        logic strobe;
        logic find_mode;
    } scan_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/dsts_table.sv -----
`default_nettype none

module dsts_table #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_TASKS)-1:0] wr_addr,
    input  wire dsts_pkg::entry_t             wr_data,
    input  wire logic [$clog2(MAX_TASKS)-1:0] rd_addr,
    output dsts_pkg::entry_t                  rd_data
);

    dsts_pkg::entry_t mem_reg [MAX_TASKS];
    dsts_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/dsts_scan_unit.sv -----
`default_nettype none

module dsts_scan_unit #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire dsts_pkg::scan_ctl_t              ctl,
    input  wire logic                             policy,
    input  wire logic [dsts_pkg::TIME_W-1:0]      now,
    input  wire logic [dsts_pkg::ID_W-1:0]        match_id,
    input  wire dsts_pkg::entry_t                 entry,
    input  wire logic [$clog2(MAX_TASKS)-1:0]     idx,
    output logic                                  found,
    output logic [$clog2(MAX_TASKS)-1:0]          best_idx,
    output dsts_pkg::entry_t                      best_entry
);

    localparam int AW = $clog2(MAX_TASKS);

    logic                               found_reg;
    logic                               found_next;
    logic [AW-1:0]                      best_idx_reg;
    logic signed [dsts_pkg::KEY_W-1:0]  best_key_reg;
    dsts_pkg::entry_t                   best_entry_reg;
    logic signed [dsts_pkg::KEY_W-1:0]  key;
    logic                               ready;
    logic                               hit;

    // slack is deadline minus now minus remaining
    always_comb begin
        if (policy) begin
            key = $signed({2'b00, entry.deadline}) - $signed({2'b00, now})
                - $signed({2'b00, entry.remaining});
        end else begin
            key = $signed({2'b00, entry.deadline});
        end
        ready = entry.arrival <= now;
        if (ctl.find_mode) begin
            hit = !found_reg && (entry.id == match_id);
        end else begin
            hit = ready && (!found_reg || key < best_key_reg);
        end
        found_next = found_reg;
        if (ctl.clear) begin
            found_next = 1'b0;
        end else if (ctl.strobe && hit) begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctl.clear && ctl.strobe && hit) begin
            best_idx_reg   <= idx;
            best_key_reg   <= key;
            best_entry_reg <= entry;
        end
    end

    assign found      = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;

endmodule

`default_nettype wire

// ----- rtl/dsts_seq.sv -----
`default_nettype none
`include "deadline_slack_task_scheduler_top_assert.svh"

module dsts_seq #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire dsts_pkg::item_t               in_item,
    output dsts_pkg::item_t                    cur_item,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output dsts_pkg::result_t                  res,
    output logic                               wr_en,
    output logic [$clog2(MAX_TASKS)-1:0]       wr_addr,
    output dsts_pkg::entry_t                   wr_data,
    output logic [$clog2(MAX_TASKS)-1:0]       rd_addr,
    input  wire dsts_pkg::entry_t              rd_data,
    output dsts_pkg::scan_ctl_t                scan_ctl,
    output logic [$clog2(MAX_TASKS)-1:0]       scan_idx,
    input  wire logic                          found,
    input  wire logic [$clog2(MAX_TASKS)-1:0]  best_idx,
    input  wire dsts_pkg::entry_t              best_entry
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    dsts_pkg::state_t  state_reg, state_next;
    dsts_pkg::item_t   item_reg, item_next;
    dsts_pkg::result_t res_reg, res_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     shift_dst;
    logic [CW-1:0]     best_succ;
    dsts_pkg::entry_t  dec_entry;

    assign shift_dst = rd_idx_reg - CW'(1);
    assign best_succ = CW'(best_idx) + CW'(1);

    always_comb begin
        dec_entry           = best_entry;
        dec_entry.remaining = best_entry.remaining - dsts_pkg::TIME_W'(1);
    end

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        res_next    = res_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data     = best_entry;
        rd_addr     = idx_reg[AW-1:0];
        scan_ctl    = '0;
        in_ready    = state_reg == dsts_pkg::S_IDLE;
        res_valid   = state_reg == dsts_pkg::S_REPORT;

        unique case (state_reg)
            dsts_pkg::S_IDLE: begin
                if (in_valid) begin
                    item_next  = in_item;
                    state_next = dsts_pkg::S_EXEC;
                end
            end
            dsts_pkg::S_EXEC: begin
                res_next = '{selected_id: '0, task_done: 1'b0, status: dsts_pkg::ST_OK};
                unique case (item_reg.op)
                    dsts_pkg::OP_ADD: begin
                        if (count_reg == CW'(MAX_TASKS)) begin
                            res_next.status = dsts_pkg::ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = '{id: item_reg.task_id,
                                           arrival: item_reg.arrival_time,
                                           deadline: item_reg.deadline_time,
                                           remaining: item_reg.exec_time};
                            count_next = count_reg + CW'(1);
                        end
                        state_next = dsts_pkg::S_REPORT;
                    end
                    dsts_pkg::OP_TICK, dsts_pkg::OP_REMOVE: begin
                        scan_ctl.clear = 1'b1;
                        idx_next       = '0;
                        state_next     = dsts_pkg::S_SCAN;
                    end
                    default: begin
                        state_next = dsts_pkg::S_REPORT;
                    end
                endcase
            end
            dsts_pkg::S_SCAN: begin
                scan_ctl.find_mode = item_reg.op == dsts_pkg::OP_REMOVE;
                scan_ctl.strobe    = rd_vld_reg;
                if (idx_reg < count_reg) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg;
                    idx_next    = idx_reg + CW'(1);
                end else if (!rd_vld_reg) begin
                    state_next = dsts_pkg::S_DECIDE;
                end
            end
            dsts_pkg::S_DECIDE: begin
                if (!found) begin
                    if (item_reg.op == dsts_pkg::OP_TICK) begin
                        res_next.status = dsts_pkg::ST_IDLE;
                    end else begin
                        res_next.status = dsts_pkg::ST_NOT_FOUND;
                    end
                    state_next = dsts_pkg::S_REPORT;
                end else if (item_reg.op == dsts_pkg::OP_TICK) begin
                    res_next.selected_id = best_entry.id;
                    // zero or one unit left: the task finishes and is retired
                    if (best_entry.remaining <= dsts_pkg::TIME_W'(1)) begin
                        res_next.task_done = 1'b1;
                        idx_next           = best_succ;
                        state_next         = dsts_pkg::S_SHIFT;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = best_idx;
                        wr_data    = dec_entry;
                        state_next = dsts_pkg::S_REPORT;
                    end
                end else begin
                    idx_next   = best_succ;
                    state_next = dsts_pkg::S_SHIFT;
                end
            end
            dsts_pkg::S_SHIFT: begin
                // close the gap, each later entry moves down one place
                if (idx_reg < count_reg) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg;
                    idx_next    = idx_reg + CW'(1);
                end
                if (rd_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = shift_dst[AW-1:0];
                    wr_data = rd_data;
                end else if (idx_reg >= count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = dsts_pkg::S_REPORT;
                end
            end
            dsts_pkg::S_REPORT: begin
                if (res_ready) begin
                    state_next = dsts_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dsts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= dsts_pkg::S_IDLE;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
    end

    assign cur_item = item_reg;
    assign res      = res_reg;
    assign scan_idx = rd_idx_reg[AW-1:0];

    `DSTS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_TASKS))
    `DSTS_ASSERT_NOW(a_write_states, wr_en,
        state_reg == dsts_pkg::S_EXEC || state_reg == dsts_pkg::S_DECIDE ||
        state_reg == dsts_pkg::S_SHIFT)
    `DSTS_ASSERT_NEXT(a_report_done, state_reg == dsts_pkg::S_REPORT && res_ready,
        state_reg == dsts_pkg::S_IDLE)
    `DSTS_ASSERT_NEXT(a_retire_count,
        state_reg == dsts_pkg::S_SHIFT && state_next == dsts_pkg::S_REPORT,
        count_reg == $past(count_reg) - CW'(1))

endmodule

`default_nettype wire

// ----- rtl/deadline_slack_task_scheduler_top.sv -----
// Deadline/slack task scheduler. Holds up to MAX_TASKS tasks in insertion order in a
// single-port-read task table. Each input word is an add (s_tuser 0), a tick (1) or a
// remove (2); each gives exactly one result word. A tick picks the ready task with
// the earliest deadline (policy 0) or least slack (policy 1), ties to the earlier
// entry, takes one unit off it and retires it when it finishes. One item at a time:
// an add writes the table and reports; a tick or remove scans all tasks held, with
// one table read feeding the shared key compare unit each cycle, and a retire or a
// remove then moves every later entry down one place to close the gap.
// The result register lets the next word in while a result waits on m_tready.
`default_nettype none

module deadline_slack_task_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // task_id, arrival_time, deadline_time, exec_time, current_time
    input  wire logic [dsts_pkg::S_TDATA_W-1:0]   s_tdata,
    // op
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // selected_id, task_done, zero fill
    output logic [dsts_pkg::M_TDATA_W-1:0]        m_tdata,
    // status
    output logic [1:0]                            m_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [0:0]                       cfg_data
);

    localparam int AW = $clog2(MAX_TASKS);

    dsts_pkg::item_t     in_item;
    dsts_pkg::item_t     cur_item;
    dsts_pkg::result_t   res;
    dsts_pkg::result_t   out_reg;
    logic                res_valid;
    logic                res_ready;
    logic                policy_reg, policy_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    dsts_pkg::entry_t    wr_data;
    logic [AW-1:0]       rd_addr;
    dsts_pkg::entry_t    rd_data;
    dsts_pkg::scan_ctl_t scan_ctl;
    logic [AW-1:0]       scan_idx;
    logic                found;
    logic [AW-1:0]       best_idx;
    dsts_pkg::entry_t    best_entry;

    always_comb begin
        in_item.op            = s_tuser;
        in_item.task_id       = s_tdata[7:0];
        in_item.arrival_time  = s_tdata[23:8];
        in_item.deadline_time = s_tdata[39:24];
        in_item.exec_time     = s_tdata[55:40];
        in_item.current_time  = s_tdata[71:56];
    end

    // result word register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
        end
        policy_next = policy_reg;
        if (cfg_valid) begin
            policy_next = cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            policy_reg   <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            policy_reg   <= policy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'b0, out_reg.task_done, out_reg.selected_id};
    assign m_tuser   = out_reg.status;

    dsts_seq #(
        .MAX_TASKS (MAX_TASKS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .cur_item   (cur_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .scan_ctl   (scan_ctl),
        .scan_idx   (scan_idx),
        .found      (found),
        .best_idx   (best_idx),
        .best_entry (best_entry)
    );

    dsts_table #(
        .MAX_TASKS (MAX_TASKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dsts_scan_unit #(
        .MAX_TASKS (MAX_TASKS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .policy     (policy_reg),
        .now        (cur_item.current_time),
        .match_id   (cur_item.task_id),
        .entry      (rd_data),
        .idx        (scan_idx),
        .found      (found),
        .best_idx   (best_idx),
        .best_entry (best_entry)
    );

endmodule

`default_nettype wire
